// ===== src/lpsc_pkg.sv =====
package lpsc_pkg;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SETS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] START_CODE_ZERO = 8'h00;
  localparam logic [7:0] START_CODE_LAST = 8'h01;

  localparam int LEN_FIELD_W = 3;
  localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_MIN   = 3'd1;
  localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_MAX   = 3'd4;
  localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_RESET = 3'd4;
  localparam logic                   MODE_RESET      = 1'b1;

  localparam int NAL_LEN_W = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_LEN_FIELD = 1'b0;
  localparam logic REG_MODE      = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int STEP_W = 3;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_START = 2'd2,
    ACT_ERROR = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_t;

  // One accepted word, reduced to what the back end must emit
  typedef struct packed {
    logic       sets;
    act_t       act;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_push_t;

endpackage

// ===== src/lpsc_front.sv =====
module lpsc_front
  import lpsc_pkg::*;
#(
  parameter int SAMPLE_SIZE_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic [SAMPLE_SIZE_BITS-1:0] in_sample_size,
  input  logic                        in_sync_flag,
  input  logic                        in_end_of_sample,
  input  logic [LEN_FIELD_W-1:0]      len_field,
  input  logic                        prefixed_mode,
  input  logic                        queue_full,
  output cmd_push_t                   push
);

  localparam int SSB = SAMPLE_SIZE_BITS;
  localparam int CW  = ((SSB > NAL_LEN_W) ? SSB : NAL_LEN_W) + 2;
  localparam logic [SSB-1:0] POS_MAX = {SSB{1'b1}};

  logic [SSB-1:0]         pos_r, pos_nxt;
  logic [NAL_LEN_W-1:0]   acc_r, acc_nxt;
  logic [LEN_FIELD_W-1:0] seen_r, seen_nxt;
  logic [NAL_LEN_W-1:0]   rem_r, rem_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   sent_r, sent_nxt;
  logic                   err_r, err_nxt;

  logic                   accept;
  logic                   first;
  logic [LEN_FIELD_W-1:0] len_eff;
  logic [LEN_FIELD_W-1:0] seen_inc;
  logic [NAL_LEN_W-1:0]   nal;
  logic [NAL_LEN_W-1:0]   rem_dec;
  logic                   short_tail;
  logic                   nal_bad;
  logic                   in_sample;
  cmd_t                   cmd;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign first    = (pos_r == '0);
  assign in_sample = (pos_r < in_sample_size);

  always_comb begin
    if (len_field == '0) begin
      len_eff = LEN_FIELD_MIN;
    end else if (len_field > LEN_FIELD_MAX) begin
      len_eff = LEN_FIELD_MAX;
    end else begin
      len_eff = len_field;
    end
  end

  assign seen_inc   = seen_r + LEN_FIELD_W'(1);
  assign nal        = {acc_r[NAL_LEN_W-9:0], in_data_byte};
  assign rem_dec    = (rem_r != '0) ? (rem_r - NAL_LEN_W'(1)) : '0;
  assign short_tail = ((SSB+1)'(pos_r) + (SSB+1)'(len_eff)) > (SSB+1)'(in_sample_size);
  assign nal_bad    = (nal == '0) ||
                      ((CW'(pos_r) + CW'(1) + CW'(nal)) > CW'(in_sample_size));

  always_comb begin
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    rem_nxt   = rem_r;
    phase_nxt = phase_r;
    sent_nxt  = sent_r;
    err_nxt   = err_r;
    cmd.sets  = first && (!sent_r || in_sync_flag);
    cmd.act   = ACT_NONE;
    cmd.data  = in_data_byte;

    if (first) begin
      sent_nxt = 1'b1;
    end

    if (prefixed_mode) begin
      unique case (phase_r)
        PH_LENGTH: begin
          if (seen_r == '0 && short_tail) begin
            phase_nxt = PH_DROP;
          end else if (seen_inc >= len_eff) begin
            if (nal_bad) begin
              cmd.act = ACT_ERROR;
              err_nxt = 1'b1;
            end else begin
              cmd.act   = ACT_START;
              rem_nxt   = nal;
              phase_nxt = PH_PAYLOAD;
            end
            acc_nxt  = '0;
            seen_nxt = '0;
          end else begin
            acc_nxt  = nal;
            seen_nxt = seen_inc;
          end
        end
        PH_PAYLOAD: begin
          if (in_sample) begin
            cmd.act = ACT_DATA;
          end
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_LENGTH;
          end
        end
        default: begin
          // drop the tail of the sample
        end
      endcase
    end else if (in_sample) begin
      cmd.act = ACT_DATA;
    end

    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + SSB'(1);
    end

    if (in_end_of_sample) begin
      pos_nxt   = '0;
      acc_nxt   = '0;
      seen_nxt  = '0;
      rem_nxt   = '0;
      phase_nxt = PH_LENGTH;
    end
  end

  assign push.cmd  = cmd;
  assign push.push = accept && !err_r && (cmd.sets || cmd.act != ACT_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      acc_r   <= '0;
      seen_r  <= '0;
      rem_r   <= '0;
      phase_r <= PH_LENGTH;
      sent_r  <= 1'b0;
      err_r   <= 1'b0;
    end else if (accept && !err_r) begin
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      rem_r   <= rem_nxt;
      phase_r <= phase_nxt;
      sent_r  <= sent_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== src/lpsc_queue.sv =====
module lpsc_queue
  import lpsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_push_t push,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output cmd_t      head
);

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = q_r[rd_ptr_r];
  assign do_push   = push.push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/lpsc_emit.sv =====
module lpsc_emit
  import lpsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  cmd_t              head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_out_byte,
  output logic [KIND_W-1:0] out_kind,
  output logic              out_last_result
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic              last_r, last_nxt;

  logic              load;
  logic [STEP_W-1:0] n_total;
  logic [STEP_W-1:0] k;
  logic              is_last;

  assign load = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    n_total = STEP_W'(head.sets);
    unique case (head.act)
      ACT_START: n_total = n_total + STEP_W'(4);
      ACT_DATA,
      ACT_ERROR: n_total = n_total + STEP_W'(1);
      default:   n_total = n_total;
    endcase
  end

  assign k       = step_r - STEP_W'(head.sets);
  assign is_last = (step_r == n_total - STEP_W'(1));
  assign pop     = load && is_last;

  always_comb begin
    byte_nxt = '0;
    kind_nxt = KIND_DATA;
    if (head.sets && step_r == '0) begin
      kind_nxt = KIND_SETS;
    end else begin
      unique case (head.act)
        ACT_DATA:  byte_nxt = head.data;
        ACT_START: byte_nxt = (k[1:0] == 2'd3) ? START_CODE_LAST : START_CODE_ZERO;
        ACT_ERROR: kind_nxt = KIND_ERROR;
        default:   kind_nxt = KIND_DATA;
      endcase
    end
    last_nxt = is_last;
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      step_nxt      = is_last ? '0 : step_r + STEP_W'(1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the word while the receiver stalls
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      kind_r <= kind_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_out_byte    = byte_r;
  assign out_kind        = kind_r;
  assign out_last_result = last_r;

endmodule

// ===== src/length_prefixed_to_start_code_nal.sv =====
// Converts length-prefixed NAL samples to start-code form, one byte a word.
// Input channel (in_valid/in_ready): one sample byte with the sample size,
// sync flag and end-of-sample mark. Output channel (out_valid/out_ready):
// one result word (byte, kind, last-of-input flag); one input gives 0 to 5.
// APB port: register 0 (address 0) length field bytes, register 1
// (address 4) prefixed mode; write only while the block is idle.
// A byte's first result passes the command queue and the output register.
// Throughput: one input byte a cycle while each byte gives one result and
// the receiver takes every result; the output stage emits one result a
// cycle while the receiver is ready, so a start code with a marker gives up
// to 5 results, absorbed by a 4-entry command queue between the classifying
// front end and the emitting back end. in_ready falls only when it is full.
// Reset clears the sample state, the parameter-set flag and the error latch,
// and loads the register defaults. While the receiver stalls the output word
// holds and the queue fills; input is taken until the queue is full.
// After an invalid length error every further byte is accepted and dropped.
module length_prefixed_to_start_code_nal
  import lpsc_pkg::*;
#(
  parameter int SAMPLE_SIZE_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic [SAMPLE_SIZE_BITS-1:0] in_sample_size,
  input  logic                        in_sync_flag,
  input  logic                        in_end_of_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_out_byte,
  output logic [KIND_W-1:0]           out_kind,
  output logic                        out_last_result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [CFG_ADDR_W-1:0]       paddr,
  input  logic [CFG_DATA_W-1:0]       pwdata,
  output logic [CFG_DATA_W-1:0]       prdata,
  output logic                        pready
);

  logic [LEN_FIELD_W-1:0] len_field_r;
  logic                   mode_r;
  logic                   cfg_wr;

  cmd_push_t push;
  cmd_t      head;
  logic      queue_full;
  logic      head_valid;
  logic      pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_field_r <= LEN_FIELD_RESET;
      mode_r      <= MODE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LEN_FIELD: len_field_r <= pwdata[LEN_FIELD_W-1:0];
        REG_MODE:      mode_r      <= pwdata[0];
        default:       mode_r      <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LEN_FIELD: prdata = CFG_DATA_W'(len_field_r);
      REG_MODE:      prdata = CFG_DATA_W'(mode_r);
      default:       prdata = '0;
    endcase
  end

  lpsc_front #(
    .SAMPLE_SIZE_BITS(SAMPLE_SIZE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_sample_size  (in_sample_size),
    .in_sync_flag    (in_sync_flag),
    .in_end_of_sample(in_end_of_sample),
    .len_field       (len_field_r),
    .prefixed_mode   (mode_r),
    .queue_full      (queue_full),
    .push            (push)
  );

  lpsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .full     (queue_full),
    .not_empty(head_valid),
    .head     (head)
  );

  lpsc_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_kind       (out_kind),
    .out_last_result(out_last_result)
  );

endmodule

// ===== tb/sv/length_prefixed_to_start_code_nal_tb.sv =====
module length_prefixed_to_start_code_nal_tb;
  import lpsc_pkg::*;

  localparam int SIZE_W = 24;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int ITEM_TARGET = 430;

  typedef struct packed {
    logic [7:0]        data;
    logic [SIZE_W-1:0] size;
    logic              sync;
    logic              eos;
  } sample_byte_t;

  typedef struct packed {
    logic [7:0]        val;
    logic [KIND_W-1:0] kind;
    logic              last;
  } nal_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_data_byte;
  logic [SIZE_W-1:0]     in_sample_size;
  logic                  in_sync_flag;
  logic                  in_end_of_sample;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_out_byte;
  logic [KIND_W-1:0]     out_kind;
  logic                  out_last_result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // converter state as the block should hold it
  logic [SIZE_W-1:0]      byte_pos;
  logic [NAL_LEN_W-1:0]   len_acc;
  logic [LEN_FIELD_W-1:0] len_seen;
  logic [NAL_LEN_W-1:0]   nal_left;
  phase_t                 conv_phase;
  logic                   sets_sent;
  logic                   fault_latched;
  logic [LEN_FIELD_W-1:0] len_field_cfg;
  logic                   prefixed_cfg;

  nal_word_t  expected_words[$];
  logic [7:0] sample_bytes[$];
  int         fail_count;
  int         items_sent;
  int         stalled_cycles;
  bit         tx_quiet;
  bit         rx_quiet;

  length_prefixed_to_start_code_nal #(
    .SAMPLE_SIZE_BITS(SIZE_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_sample_size(in_sample_size),
    .in_sync_flag(in_sync_flag),
    .in_end_of_sample(in_end_of_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_out_byte(out_out_byte),
    .out_kind(out_kind),
    .out_last_result(out_last_result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic nal_word_t make_word(input logic [7:0] val, input logic [KIND_W-1:0] kind);
    nal_word_t w;
    w.val = val;
    w.kind = kind;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic int field_bytes();
    if (len_field_cfg == 3'd0) return int'(LEN_FIELD_MIN);
    if (len_field_cfg > LEN_FIELD_MAX) return int'(LEN_FIELD_MAX);
    return int'(len_field_cfg);
  endfunction

  // Work out the words one accepted byte must produce and queue them
  function automatic void predict_byte(input sample_byte_t it);
    nal_word_t   produced[$];
    logic [63:0] pos;
    logic [63:0] lf;
    if (fault_latched) return;
    pos = 64'(byte_pos);
    lf = 64'(field_bytes());
    if (byte_pos == '0) begin
      if (!sets_sent || it.sync) produced.push_back(make_word(8'h00, KIND_SETS));
      sets_sent = 1'b1;
    end
    if (prefixed_cfg) begin
      case (conv_phase)
        PH_LENGTH: begin
          if (len_seen == '0 && pos + lf > 64'(it.size)) begin
            conv_phase = PH_DROP;
          end else begin
            len_acc = {len_acc[NAL_LEN_W-9:0], it.data};
            len_seen = len_seen + 3'd1;
            if (64'(len_seen) >= lf) begin
              if (len_acc == '0 || pos + 64'd1 + 64'(len_acc) > 64'(it.size)) begin
                produced.push_back(make_word(8'h00, KIND_ERROR));
                fault_latched = 1'b1;
              end else begin
                repeat (3) produced.push_back(make_word(START_CODE_ZERO, KIND_DATA));
                produced.push_back(make_word(START_CODE_LAST, KIND_DATA));
                nal_left = len_acc;
                conv_phase = PH_PAYLOAD;
              end
              len_acc = '0;
              len_seen = '0;
            end
          end
        end
        PH_PAYLOAD: begin
          if (byte_pos < it.size) produced.push_back(make_word(it.data, KIND_DATA));
          if (nal_left != '0) nal_left = nal_left - NAL_LEN_W'(1);
          if (nal_left == '0) conv_phase = PH_LENGTH;
        end
        default: ;
      endcase
    end else if (byte_pos < it.size) begin
      produced.push_back(make_word(it.data, KIND_DATA));
    end
    if (byte_pos != '1) byte_pos = byte_pos + SIZE_W'(1);
    if (it.eos) begin
      byte_pos = '0;
      len_acc = '0;
      len_seen = '0;
      nal_left = '0;
      conv_phase = PH_LENGTH;
    end
    if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
    foreach (produced[i]) expected_words.push_back(produced[i]);
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic [SIZE_W-1:0] sz,
                           input logic sy, input logic eo);
    int gap;
    sample_byte_t it;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data_byte = d;
    in_sample_size = sz;
    in_sync_flag = sy;
    in_end_of_sample = eo;
    do @(posedge clk); while (!in_ready);
    it.data = d;
    it.size = sz;
    it.sync = sy;
    it.eos = eo;
    predict_byte(it);
    items_sent++;
  endtask

  // Send the bytes held in sample_bytes, end mark on the last one
  task automatic send_sample(input logic [SIZE_W-1:0] sz, input logic sy);
    foreach (sample_bytes[i])
      send_byte(sample_bytes[i], sz, sy, i == sample_bytes.size() - 1);
  endtask

  // Hold input until every expected word is out, then let the queue settle
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] want;
    drain_results();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_LEN_FIELD) len_field_cfg = val[LEN_FIELD_W-1:0];
    else prefixed_cfg = val[0];
    // read back
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    want = (idx == REG_LEN_FIELD) ? CFG_DATA_W'(len_field_cfg) : CFG_DATA_W'(prefixed_cfg);
    if (prdata !== want) begin
      $error("prdata: expected %0h, got %0h", want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_first_sample_start_code();
    sample_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    send_sample(24'd5, 1'b0);
  endtask

  task automatic test_one_byte_prefix_sync();
    write_reg(REG_LEN_FIELD, 32'd1);
    sample_bytes = {8'h01, 8'h00, 8'h01, 8'h7F};
    send_sample(24'd4, 1'b1);
  endtask

  task automatic test_short_tail_and_overrun();
    write_reg(REG_LEN_FIELD, 32'd2);
    sample_bytes = {8'h00, 8'h02, 8'hAA, 8'h55, 8'h0E, 8'h33};
    send_sample(24'd5, 1'b0);
  endtask

  task automatic test_passthrough();
    write_reg(REG_MODE, 32'd0);
    sample_bytes = {8'h00, 8'hFF, 8'h12};
    send_sample(24'd2, 1'b1);
  endtask

  task automatic test_three_byte_prefix_early_end();
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_LEN_FIELD, 32'd3);
    sample_bytes = {8'h00, 8'h00, 8'h05, 8'h01};
    send_sample(24'd9, 1'b0);
  endtask

  task automatic test_reconfig_mid_sample();
    write_reg(REG_LEN_FIELD, 32'd7);
    send_byte(8'h00, 24'd4, 1'b0, 1'b0);
    send_byte(8'h00, 24'd4, 1'b0, 1'b0);
    write_reg(REG_MODE, 32'd0);
    send_byte(8'h9C, 24'd4, 1'b0, 1'b0);
    send_byte(8'h3D, 24'd4, 1'b0, 1'b1);
  endtask

  task automatic test_random_samples();
    int                pick;
    int                eff;
    int                cut;
    int                shrink_at;
    logic [31:0]       nal_len;
    logic [31:0]       first_len;
    logic [SIZE_W-1:0] sz;
    logic [SIZE_W-1:0] shrunk;
    logic              sy;
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_LEN_FIELD, 32'd0);
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) write_reg(REG_LEN_FIELD, $urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0)
        write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 3) != 0));
      tx_quiet = $urandom_range(0, 3) == 0;
      rx_quiet = $urandom_range(0, 3) == 0;
      sy = 1'($urandom_range(0, 1));
      eff = field_bytes();
      pick = $urandom_range(0, 9);
      sample_bytes = {};
      if (!prefixed_cfg) begin
        repeat ($urandom_range(1, 8)) sample_bytes.push_back(8'($urandom));
        sz = SIZE_W'(sample_bytes.size());
        if (pick >= 8) sz = SIZE_W'($urandom_range(0, 24'hFFFFFF));
        else if (pick >= 5) sz = SIZE_W'($urandom_range(0, sample_bytes.size()));
        send_sample(sz, sy);
      end else begin
        first_len = 0;
        repeat ($urandom_range(1, 3)) begin
          nal_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
          if (first_len == 0) first_len = nal_len;
          for (int k = eff - 1; k >= 0; k--) sample_bytes.push_back(8'(nal_len >> (8 * k)));
          repeat (nal_len) sample_bytes.push_back(8'($urandom));
        end
        sz = SIZE_W'(sample_bytes.size());
        case (pick)
          6: begin
            // short tail: fewer bytes than a length field
            repeat ($urandom_range(0, eff - 1)) sample_bytes.push_back(8'($urandom));
            sz = SIZE_W'(sample_bytes.size());
          end
          7: repeat ($urandom_range(1, 3)) sample_bytes.push_back(8'($urandom));
          8: begin
            sz = SIZE_W'($urandom_range(sz, 24'hFFFFFF));
            cut = $urandom_range(1, sample_bytes.size());
            while (sample_bytes.size() > cut) void'(sample_bytes.pop_back());
          end
          default: if ($urandom_range(0, 3) == 0) sz = SIZE_W'($urandom_range(sz, 24'hFFFFFF));
        endcase
        if (pick == 9) begin
          // declared size drops inside the first payload; drop the rest
          shrink_at = eff + $urandom_range(0, first_len - 1);
          shrunk = SIZE_W'($urandom_range(0, shrink_at));
          for (int i = 0; i < sample_bytes.size(); i++)
            send_byte(sample_bytes[i], (i >= shrink_at) ? shrunk : sz, sy,
                      i == sample_bytes.size() - 1);
        end else begin
          send_sample(sz, sy);
        end
      end
    end
  endtask

  // The error latch holds until reset, so this runs last
  task automatic test_bad_length();
    int eff;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    eff = $urandom_range(1, 4);
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_LEN_FIELD, CFG_DATA_W'(eff));
    sample_bytes = {};
    repeat (eff - 1) sample_bytes.push_back(8'h00);
    // zero length, or a NAL that runs past the sample
    sample_bytes.push_back($urandom_range(0, 1) ? 8'h00 : 8'h09);
    repeat (3) sample_bytes.push_back(8'($urandom));
    send_sample(24'd8, 1'b1);
    sample_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h5A};
    send_sample(24'd5, 1'b1);
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_words
    nal_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte %02h kind %0d last %0b",
               out_out_byte, out_kind, out_last_result);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_out_byte !== want.val) begin
          $error("out_byte: expected %02h, got %02h", want.val, out_out_byte);
          fail_count++;
        end
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          fail_count++;
        end
        if (out_last_result !== want.last) begin
          $error("last_result: expected %0b, got %0b", want.last, out_last_result);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_sample_size = '0;
    in_sync_flag = 1'b0;
    in_end_of_sample = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    fail_count = 0;
    items_sent = 0;
    stalled_cycles = 0;
    byte_pos = '0;
    len_acc = '0;
    len_seen = '0;
    nal_left = '0;
    conv_phase = PH_LENGTH;
    sets_sent = 1'b0;
    fault_latched = 1'b0;
    len_field_cfg = LEN_FIELD_RESET;
    prefixed_cfg = MODE_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_first_sample_start_code();
    test_one_byte_prefix_sync();
    test_short_tail_and_overrun();
    test_passthrough();
    test_three_byte_prefix_early_end();
    test_reconfig_mid_sample();
    test_random_samples();
    test_bad_length();
    drain_results();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
